// ===== design/fss_pkg.sv =====
// Package for the fuzzy subsequence scorer: shared types, score constants,
// register indexes and the ASCII case-fold function. No dependencies.
package fss_pkg;

    // Fixed widths
    localparam int QUERY_BYTES = 8;
    localparam int QUERY_W     = QUERY_BYTES * 8;
    localparam int QLEN_W      = 4;
    localparam int SCORE_W     = 10;

    // Score terms
    localparam logic [SCORE_W-1:0] SCORE_BASE   = 10'd100;
    localparam logic [SCORE_W-1:0] PREFIX_BONUS = 10'd50;
    localparam logic [SCORE_W-1:0] SUBSTR_BONUS = 10'd30;
    localparam logic [SCORE_W-1:0] WORD_BONUS   = 10'd10;

    // Word separators and case-fold constants (raw bytes)
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_QUERY_CHARS  = 1'b0,
        CFG_QUERY_LENGTH = 1'b1
    } t_cfg_reg;

    // Active query, bytes already case-folded, length already clamped
    typedef struct packed {
        logic [QUERY_W-1:0] chars;
        logic [QLEN_W-1:0]  length;
    } t_query;

    // One result item
    typedef struct packed {
        logic               matched;
        logic [SCORE_W-1:0] score;
    } t_result;

    // Map 'A'..'Z' onto 'a'..'z', everything else passes
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== design/fuzzy_subsequence_scorer.sv =====
// Top level of the fuzzy subsequence scorer: input register, match core,
// result register and configuration port. Depends on fss_pkg, fss_cfg_regs, fss_match_core.
//
//  Channel   Direction  Request contents
//  s_axis    in         tdata[7:0] name_char, tlast last_char
//  m_axis    out        tdata[9:0] score (unsigned, upper bits zero), tuser matched
//  cfg       in         index 0 query_chars (64 bits), index 1 query_length (4 bits)
//
// One name byte per cycle unless a byte with tlast waits on a stalled result;
// a byte passes the input register, then its score lands in the result register.
// Only the byte with tlast produces a result. A stalled result holds only
// bytes with tlast behind it; other bytes keep flowing. Reset is synchronous
// and clears all match state and both query registers. Config is always ready.
module fuzzy_subsequence_scorer #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_NAME  = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // name byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] name_char
    input  logic        s_axis_tlast,
    // score stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] score, [15:10] zero
    output logic        m_axis_tuser,   // [0] matched
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    fss_pkg::t_query  query;
    fss_pkg::t_result result;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       advance;
    logic       r_out_valid;
    logic       r_out_matched;
    logic [fss_pkg::SCORE_W-1:0] r_out_score;

    // Configuration
    assign o_cfg_ready = 1'b1;

    fss_cfg_regs #(
        .MAX_QUERY (MAX_QUERY)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (fss_pkg::t_cfg_reg'(i_cfg_index)),
        .i_wr_data  (i_cfg_data),
        .o_query    (query)
    );

    // Byte in the input register moves on unless it needs a busy result slot
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    fss_match_core #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_NAME  (MAX_NAME)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .i_query   (query),
        .o_result  (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_matched <= result.matched;
            r_out_score   <= result.score;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - fss_pkg::SCORE_W){1'b0}}, r_out_score};
    assign m_axis_tuser  = r_out_matched;
    assign m_axis_tlast  = 1'b1;

endmodule

// ===== design/fss_cfg_regs.sv =====
// Query configuration registers; folds query bytes on write and clamps length.
// Depends on fss_pkg.
module fss_cfg_regs #(
    parameter int MAX_QUERY = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  fss_pkg::t_cfg_reg          i_wr_index,
    input  logic [fss_pkg::QUERY_W-1:0] i_wr_data,
    output fss_pkg::t_query            o_query
);

    localparam logic [fss_pkg::QLEN_W-1:0] MaxQ = fss_pkg::QLEN_W'(MAX_QUERY);

    logic [fss_pkg::QUERY_W-1:0] r_chars;
    logic [fss_pkg::QLEN_W-1:0]  r_length;
    logic [fss_pkg::QUERY_W-1:0] n_chars;

    // Fold every byte of an incoming query word
    always_comb begin
        for (int k = 0; k < fss_pkg::QUERY_BYTES; k++) begin
            n_chars[k*8 +: 8] = fss_pkg::fold_char(i_wr_data[k*8 +: 8]);
        end
    end

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars  <= '0;
            r_length <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                fss_pkg::CFG_QUERY_CHARS:  r_chars  <= n_chars;
                fss_pkg::CFG_QUERY_LENGTH: r_length <= i_wr_data[fss_pkg::QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_query.chars  = r_chars;
    assign o_query.length = (r_length > MaxQ) ? MaxQ : r_length;

endmodule

// ===== design/fss_match_core.sv =====
// Per-name match state and combinational scoring of one name byte.
// Depends on fss_pkg.
module fss_match_core #(
    parameter int MAX_QUERY = 8,
    parameter int MAX_NAME  = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_char,
    input  logic               i_last,
    input  fss_pkg::t_query    i_query,
    output fss_pkg::t_result   o_result
);

    localparam int LEN_W = $clog2(MAX_NAME + 1);
    localparam int WIN_W = MAX_QUERY * 8;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_NAME);
    localparam int SW = fss_pkg::SCORE_W;

    logic [fss_pkg::QLEN_W-1:0] r_qpos,  n_qpos;
    logic [fss_pkg::QLEN_W-1:0] r_hits,  n_hits;
    logic                       r_prefix, n_prefix;
    logic                       r_substr, n_substr;
    logic [LEN_W-1:0]           r_len,   n_len;
    logic [7:0]                 r_prev;
    logic [WIN_W-1:0]           r_win,   n_win;

    logic [7:0]                 c;
    logic [fss_pkg::QLEN_W-1:0] qlen;
    logic [7:0]                 qbyte;
    logic                       at_start, word_start, char_hit;
    logic [MAX_QUERY-1:0]       lane_ok;
    logic [fss_pkg::QLEN_W-1:0] lane_idx;
    logic                       window_hit;

    assign c        = fss_pkg::fold_char(i_char);
    assign qlen     = i_query.length;
    assign qbyte    = i_query.chars[{r_qpos[2:0], 3'b000} +: 8];
    assign at_start = (r_len == '0);
    assign word_start = at_start || r_prev == fss_pkg::CHAR_SPACE
                        || r_prev == fss_pkg::CHAR_UNDERSCORE;
    assign char_hit = (r_qpos < qlen) && (c == qbyte);

    // Greedy in-order match, prefix and word-start hits
    always_comb begin
        n_qpos   = r_qpos;
        n_hits   = r_hits;
        n_prefix = r_prefix;
        if (char_hit) begin
            n_qpos = r_qpos + 1'b1;
            if (r_qpos == '0 && at_start) begin
                n_prefix = 1'b1;
            end
            if (word_start) begin
                n_hits = r_hits + 1'b1;
            end
        end
        n_len = (r_len < MaxLen) ? r_len + 1'b1 : r_len;
    end

    // Sliding window of the newest folded bytes, newest in the low byte
    always_comb begin
        n_win[7:0] = c;
        for (int k = 1; k < MAX_QUERY; k++) begin
            n_win[k*8 +: 8] = r_win[(k-1)*8 +: 8];
        end
    end

    // Contiguous query check: window byte k against query byte qlen-1-k
    always_comb begin
        for (int k = 0; k < MAX_QUERY; k++) begin
            lane_idx   = qlen - 1'b1 - fss_pkg::QLEN_W'(k);
            lane_ok[k] = (fss_pkg::QLEN_W'(k) >= qlen)
                         || (n_win[k*8 +: 8] == i_query.chars[{lane_idx[2:0], 3'b000} +: 8]);
        end
        window_hit = (&lane_ok) && (n_len >= LEN_W'(qlen));
        n_substr   = r_substr || (qlen == '0) || window_hit;
    end

    // Score from the state after this byte (modulo the score width)
    always_comb begin
        o_result.matched = (n_qpos >= qlen);
        o_result.score   = '0;
        if (o_result.matched) begin
            o_result.score = fss_pkg::SCORE_BASE
                           + (n_prefix ? fss_pkg::PREFIX_BONUS : '0)
                           + (n_substr ? fss_pkg::SUBSTR_BONUS : '0)
                           + SW'(n_hits) * fss_pkg::WORD_BONUS
                           - SW'(n_len);
        end
    end

    // State update; the last byte clears the name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpos   <= '0;
            r_hits   <= '0;
            r_prefix <= 1'b0;
            r_substr <= 1'b0;
            r_len    <= '0;
            r_prev   <= '0;
            r_win    <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_qpos   <= '0;
                r_hits   <= '0;
                r_prefix <= 1'b0;
                r_substr <= 1'b0;
                r_len    <= '0;
                r_prev   <= '0;
                r_win    <= '0;
            end else begin
                r_qpos   <= n_qpos;
                r_hits   <= n_hits;
                r_prefix <= n_prefix;
                r_substr <= n_substr;
                r_len    <= n_len;
                r_prev   <= i_char;
                r_win    <= n_win;
            end
        end
    end

endmodule

// ===== design/fss_checker.sv =====
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
// Depends on fuzzy_subsequence_scorer.
module fss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Results are cleared by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its score
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An unmatched name scores zero
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("nonzero score without a match");

    // Input backpressure only comes from a waiting result
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
